// ----- rtl/core/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg
// shared types, constants and helpers of the page registration checker
// ----------------------------------------------------------------------------
package prc_pkg;

  // sizing of the registration
  localparam int PAGE_COUNT   = 759;
  localparam int WINDOW_PAGES = 786432;
  localparam int PAGE_BYTES   = 16384;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = $clog2(WINDOW_PAGES);
  localparam int OFFSET_W   = PAGE_W + PAGE_SHIFT;
  localparam int INDEX_W    = 10;

  // ownership map held as rows of bits
  localparam int ROW_BITS  = 64;
  localparam int ROW_SEL_W = $clog2(ROW_BITS);
  localparam int MEM_ROWS  = (WINDOW_PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = $clog2(MEM_ROWS);

  localparam logic [63:0] START_MAGIC  = 64'd12435456;
  localparam logic [63:0] WINDOW_BASE  = 64'h0000_0100_0000_0000;
  localparam logic [63:0] WINDOW_END   =
    WINDOW_BASE + 64'(WINDOW_PAGES) * 64'(PAGE_BYTES);
  localparam logic [63:0] COMMIT_VALUE = 64'd1;
  localparam logic [INDEX_W-1:0] PAGE_COUNT_V = INDEX_W'(PAGE_COUNT);

  // register offsets
  localparam logic [7:0] OFF_START = 8'd0;
  localparam logic [7:0] OFF_PAGE  = 8'd8;
  localparam logic [7:0] OFF_READY = 8'd16;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_ACCESS = 3'd1,
    ERR_PAGE   = 3'd2,
    ERR_DUP    = 3'd3,
    ERR_SEQ    = 3'd4
  } err_code_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  offset;
    logic        full_width;
    logic [63:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic                rdata;
    err_code_t           error_code;
    logic                ready_res;
    logic                entry_valid;
    logic [INDEX_W-1:0]  entry_index;
    logic [OFFSET_W-1:0] entry_offset;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [ROW_W-1:0]    addr;
    logic [ROW_BITS-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic               s1_valid;
    logic               committed;
    logic [INDEX_W-1:0] pages_taken;
    err_code_t          latched_error;
  } status_t;

  // page number inside the window
  function automatic logic [PAGE_W-1:0] page_of(input logic [63:0] addr);
    logic [63:0] rel;
    rel = addr - WINDOW_BASE;
    return rel[OFFSET_W-1:PAGE_SHIFT];
  endfunction

endpackage

// ----- rtl/core/page_registration_checker_top.sv -----
// ----------------------------------------------------------------------------
// page_registration_checker_top
// bus register block that registers a fixed set of pages into a manifest
// ----------------------------------------------------------------------------
// usage:
//   each transfer on the s_ side is one register access (read or write).
//   a start write of the magic length at offset 0 opens a session, then
//   page addresses are written at offset 8, and a write of 1 at offset 16
//   commits once all pages are in. each access gives exactly one transfer
//   on the m_ side with the read data, the sticky error code, the ready
//   flag and, for an accepted page, its manifest index and window offset.
// pipeline and throughput:
//   the access waits in the check stage, its result in the output register.
//   one access is taken per cycle while the output is not held; the rate is
//   set by the single read-modify-write of the ownership bitmap ram, whose
//   last write is forwarded to the next access when both touch the same row.
// reset:
//   session, commit, count and error are cleared at once; the ownership
//   bitmap is then cleared one row per cycle through all MEM_ROWS (12288)
//   rows, and s_tready stays low until that pass is done.
// stalls:
//   when m_tready is low the output register holds its transfer, one more
//   access can wait in the check stage, and s_tready drops after that.
// ----------------------------------------------------------------------------
module page_registration_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // offset[7:0], wdata[71:8]
  input  logic [1:0]  s_tuser,   // command[0], full_width[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // rdata[0], error_code[3:1], ready_res[4],
                                 // entry_valid[5], entry_index[15:6],
                                 // entry_offset[49:16], zero[55:50]
);

  logic                         clearing;
  logic [prc_pkg::ROW_W-1:0]    clear_row;
  logic                         pipe_en;
  logic                         in_accept;
  prc_pkg::in_item_t            in_item;
  prc_pkg::result_t             result;
  prc_pkg::status_t             status;
  prc_pkg::mem_wr_t             ctrl_wr;
  prc_pkg::mem_wr_t             ram_wr;
  logic [prc_pkg::ROW_W-1:0]    rd_addr;
  logic [prc_pkg::ROW_BITS-1:0] rd_data;

  // unpack the access
  assign in_item.command    = s_tuser[0];
  assign in_item.full_width = s_tuser[1];
  assign in_item.offset     = s_tdata[7:0];
  assign in_item.wdata      = s_tdata[71:8];

  // output register moves when empty or being drained
  assign pipe_en   = !m_tvalid || m_tready;
  assign s_tready  = !clearing && (!status.s1_valid || pipe_en);
  assign in_accept = s_tvalid && s_tready;

  // bitmap clear pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_row <= '0;
    end else if (clearing) begin
      if (clear_row == prc_pkg::ROW_W'(prc_pkg::MEM_ROWS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clear_row <= clear_row + prc_pkg::ROW_W'(1);
      end
    end
  end

  // no access is in flight while clearing, so the ports never collide
  assign ram_wr.en   = clearing || ctrl_wr.en;
  assign ram_wr.addr = clearing ? clear_row : ctrl_wr.addr;
  assign ram_wr.data = clearing ? '0 : ctrl_wr.data;

  prc_owner_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_item   (in_item),
    .advance   (pipe_en),
    .rd_data   (rd_data),
    .rd_addr   (rd_addr),
    .mem_wr    (ctrl_wr),
    .result    (result),
    .status    (status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pipe_en) begin
      m_tvalid <= status.s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en && status.s1_valid) begin
      m_tdata <= {6'd0, result.entry_offset, result.entry_index, result.entry_valid,
                  result.ready_res, 3'(result.error_code), result.rdata};
    end
  end

`ifndef SYNTHESIS
  // a latched error never changes
  assert property (@(posedge clk) disable iff (rst)
    (status.latched_error != prc_pkg::ERR_NONE) |=>
      (status.latched_error == $past(status.latched_error)))
    else $error("latched error changed");

  // commit only with the full page count
  assert property (@(posedge clk) disable iff (rst)
    status.committed |-> (status.pages_taken == prc_pkg::PAGE_COUNT_V))
    else $error("committed without full page count");

  // an accepted page never comes with an error
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5]) |-> (m_tdata[3:1] == 3'(prc_pkg::ERR_NONE)))
    else $error("manifest entry with error");

  // nothing reaches the check stage during the clear pass
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !status.s1_valid)
    else $error("access in flight during bitmap clear");
`endif

endmodule

// ----- rtl/core/prc_owner_ram.sv -----
// ----------------------------------------------------------------------------
// prc_owner_ram
// ownership bitmap, one write port and one registered read port
// ----------------------------------------------------------------------------
module prc_owner_ram (
  input  logic                         clk,
  input  prc_pkg::mem_wr_t             wr,
  input  logic [prc_pkg::ROW_W-1:0]    rd_addr,
  output logic [prc_pkg::ROW_BITS-1:0] rd_data
);

  logic [prc_pkg::ROW_BITS-1:0] mem [prc_pkg::MEM_ROWS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read before write on the same address
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/prc_ctrl.sv -----
// ----------------------------------------------------------------------------
// prc_ctrl
// session state, access checks and bitmap read-modify-write
// ----------------------------------------------------------------------------
module prc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_accept,
  input  prc_pkg::in_item_t            in_item,
  input  logic                         advance,
  input  logic [prc_pkg::ROW_BITS-1:0] rd_data,
  output logic [prc_pkg::ROW_W-1:0]    rd_addr,
  output prc_pkg::mem_wr_t             mem_wr,
  output prc_pkg::result_t             result,
  output prc_pkg::status_t             status
);

  logic                          s1_valid;
  prc_pkg::in_item_t             s1_item;
  logic                          session_started;
  logic                          session_started_next;
  logic                          committed;
  logic                          committed_next;
  logic [prc_pkg::INDEX_W-1:0]   pages_taken;
  logic [prc_pkg::INDEX_W-1:0]   pages_taken_next;
  prc_pkg::err_code_t            latched_error;
  prc_pkg::err_code_t            latched_error_next;
  logic                          fwd_valid;
  logic [prc_pkg::ROW_W-1:0]     fwd_row;
  logic [prc_pkg::ROW_BITS-1:0]  fwd_data;

  logic                          fire;
  logic [prc_pkg::PAGE_W-1:0]    in_page;
  logic [prc_pkg::PAGE_W-1:0]    s1_page;
  logic [prc_pkg::ROW_W-1:0]     s1_row;
  logic [prc_pkg::ROW_SEL_W-1:0] bit_sel;
  logic [prc_pkg::ROW_BITS-1:0]  row_cur;
  logic [prc_pkg::ROW_BITS-1:0]  bit_mask;
  logic [63:0]                   rel;
  logic                          page_bad;
  logic                          raise;
  prc_pkg::err_code_t            raise_code;
  logic                          take_page;

  assign fire    = s1_valid && advance;
  assign in_page = prc_pkg::page_of(in_item.wdata);
  assign s1_page = prc_pkg::page_of(s1_item.wdata);
  assign s1_row  = s1_page[prc_pkg::PAGE_W-1:prc_pkg::ROW_SEL_W];
  assign bit_sel = s1_page[prc_pkg::ROW_SEL_W-1:0];
  assign rel     = s1_item.wdata - prc_pkg::WINDOW_BASE;

  // a held item reissues its own read so the data stays current
  assign rd_addr = in_accept ? in_page[prc_pkg::PAGE_W-1:prc_pkg::ROW_SEL_W] : s1_row;

  // row written at the last edge is not yet visible in the read data
  assign row_cur  = (fwd_valid && fwd_row == s1_row) ? fwd_data : rd_data;
  assign bit_mask = prc_pkg::ROW_BITS'(1) << bit_sel;

  assign page_bad = (s1_item.wdata[prc_pkg::PAGE_SHIFT-1:0] != '0)
                 || (s1_item.wdata < prc_pkg::WINDOW_BASE)
                 || (s1_item.wdata >= prc_pkg::WINDOW_END);

  always_comb begin
    session_started_next = session_started;
    committed_next       = committed;
    pages_taken_next     = pages_taken;
    raise                = 1'b0;
    raise_code           = prc_pkg::ERR_NONE;
    take_page            = 1'b0;
    result               = '0;
    if (s1_item.command == prc_pkg::CMD_READ) begin
      result.rdata = (s1_item.offset == prc_pkg::OFF_READY) && s1_item.full_width && committed;
    end else if (!s1_item.full_width || committed || latched_error != prc_pkg::ERR_NONE) begin
      raise      = 1'b1;
      raise_code = prc_pkg::ERR_ACCESS;
    end else if (s1_item.offset == prc_pkg::OFF_START && !session_started
                 && s1_item.wdata == prc_pkg::START_MAGIC) begin
      session_started_next = 1'b1;
    end else if (s1_item.offset == prc_pkg::OFF_PAGE && session_started
                 && pages_taken < prc_pkg::PAGE_COUNT_V) begin
      if (page_bad) begin
        raise      = 1'b1;
        raise_code = prc_pkg::ERR_PAGE;
      end else if ((row_cur & bit_mask) != '0) begin
        raise      = 1'b1;
        raise_code = prc_pkg::ERR_DUP;
      end else begin
        take_page           = 1'b1;
        result.entry_valid  = 1'b1;
        result.entry_index  = pages_taken;
        result.entry_offset = rel[prc_pkg::OFFSET_W-1:0];
        pages_taken_next    = pages_taken + prc_pkg::INDEX_W'(1);
      end
    end else if (s1_item.offset == prc_pkg::OFF_READY && s1_item.wdata == prc_pkg::COMMIT_VALUE
                 && pages_taken == prc_pkg::PAGE_COUNT_V) begin
      committed_next = 1'b1;
    end else begin
      raise      = 1'b1;
      raise_code = prc_pkg::ERR_SEQ;
    end
    // first error wins
    latched_error_next = (raise && latched_error == prc_pkg::ERR_NONE) ? raise_code
                                                                      : latched_error;
    result.error_code = latched_error_next;
    result.ready_res  = committed_next;
  end

  assign mem_wr.en   = fire && take_page;
  assign mem_wr.addr = s1_row;
  assign mem_wr.data = row_cur | bit_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      session_started <= 1'b0;
      committed       <= 1'b0;
      pages_taken     <= '0;
      latched_error   <= prc_pkg::ERR_NONE;
      fwd_valid       <= 1'b0;
    end else begin
      if (!s1_valid || advance) begin
        s1_valid <= in_accept;
      end
      if (fire) begin
        session_started <= session_started_next;
        committed       <= committed_next;
        pages_taken     <= pages_taken_next;
        latched_error   <= latched_error_next;
      end
      fwd_valid <= mem_wr.en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_item;
    end
    if (mem_wr.en) begin
      fwd_row  <= mem_wr.addr;
      fwd_data <= mem_wr.data;
    end
  end

  assign status.s1_valid      = s1_valid;
  assign status.committed     = committed;
  assign status.pages_taken   = pages_taken;
  assign status.latched_error = latched_error;

endmodule
